// ===== hdl/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned AddrW = 3;
	localparam int unsigned DataW = 32;

	localparam logic [ByteW-1:0] HeadByteReset  = 8'd90;
	localparam logic [ByteW-1:0] MaxLengthReset = 8'd64;

	typedef enum logic [1:0] {
		ST_PAYLOAD = 2'd0,
		ST_OK      = 2'd1,
		ST_SUMERR  = 2'd2,
		ST_LENERR  = 2'd3
	} status_t;

	typedef enum logic {
		REG_HEAD_BYTE  = 1'b0,
		REG_MAX_LENGTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] head_byte;
		logic [ByteW-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic             frame_end;
		status_t          status;
		logic [ByteW-1:0] frame_length;
		logic [ByteW-1:0] command;
		logic [ByteW-1:0] byte_index;
		logic [ByteW-1:0] out_byte;
	} result_t;

endpackage

// ===== hdl/sfr_cfg_regs.sv =====
`timescale 1ns / 1ps

module sfr_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sfr_pkg::AddrW-1:0] paddr,
	input  logic [sfr_pkg::DataW-1:0] pwdata,
	output logic [sfr_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output sfr_pkg::cfg_t             cfg
);

	sfr_pkg::cfg_t    cfg_q;
	sfr_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = sfr_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte  <= sfr_pkg::HeadByteReset;
			cfg_q.max_length <= sfr_pkg::MaxLengthReset;
		end else if (wr_en) begin
			case (idx)
				sfr_pkg::REG_HEAD_BYTE:  cfg_q.head_byte  <= pwdata[sfr_pkg::ByteW-1:0];
				sfr_pkg::REG_MAX_LENGTH: cfg_q.max_length <= pwdata[sfr_pkg::ByteW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sfr_pkg::REG_HEAD_BYTE:
				prdata = {{(sfr_pkg::DataW-sfr_pkg::ByteW){1'b0}}, cfg_q.head_byte};
			sfr_pkg::REG_MAX_LENGTH:
				prdata = {{(sfr_pkg::DataW-sfr_pkg::ByteW){1'b0}}, cfg_q.max_length};
			default:
				prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/sfr_parser.sv =====
`timescale 1ns / 1ps

module sfr_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [sfr_pkg::ByteW-1:0] rx_byte,
	input  sfr_pkg::cfg_t             cfg,
	output logic                      res_valid,
	output sfr_pkg::result_t          res
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_SUM  = 3'd4
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic [sfr_pkg::ByteW-1:0] sum_q, sum_d;
	logic [sfr_pkg::ByteW-1:0] count_q, count_d;
	logic [sfr_pkg::ByteW-1:0] exp_len_q, exp_len_d;
	logic [sfr_pkg::ByteW-1:0] command_q, command_d;
	logic [sfr_pkg::ByteW-1:0] count_inc;

	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		count_d   = count_q;
		exp_len_d = exp_len_q;
		command_d = command_q;
		res_valid = 1'b0;
		res.out_byte     = rx_byte;
		res.byte_index   = '0;
		res.command      = command_q;
		res.frame_length = exp_len_q;
		res.status       = sfr_pkg::ST_PAYLOAD;
		res.frame_end    = 1'b0;
		case (phase_q)
			PH_CMD: begin
				command_d = rx_byte;
				sum_d     = sum_q + rx_byte;
				phase_d   = PH_LEN;
			end
			PH_LEN: begin
				if (rx_byte <= cfg.max_length) begin
					exp_len_d = rx_byte;
					count_d   = '0;
					sum_d     = sum_q + rx_byte;
					phase_d   = (rx_byte == '0) ? PH_SUM : PH_DATA;
				end else begin
					res_valid        = 1'b1;
					res.frame_length = rx_byte;
					res.status       = sfr_pkg::ST_LENERR;
					res.frame_end    = 1'b1;
					sum_d            = '0;
					phase_d          = PH_HUNT;
				end
			end
			PH_DATA: begin
				res_valid      = 1'b1;
				res.byte_index = count_q;
				sum_d          = sum_q + rx_byte;
				count_d        = count_inc;
				if (count_inc == exp_len_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				res_valid     = 1'b1;
				res.status    = (sum_q == rx_byte) ? sfr_pkg::ST_OK : sfr_pkg::ST_SUMERR;
				res.frame_end = 1'b1;
				sum_d         = '0;
				phase_d       = PH_HUNT;
			end
			default: begin
				if (rx_byte == cfg.head_byte) begin
					sum_d   = rx_byte;
					phase_d = PH_CMD;
				end else begin
					sum_d   = '0;
					phase_d = PH_HUNT;
				end
			end
		endcase
		res_valid = res_valid && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			sum_q     <= '0;
			count_q   <= '0;
			exp_len_q <= '0;
			command_q <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			sum_q     <= sum_d;
			count_q   <= count_d;
			exp_len_q <= exp_len_d;
			command_q <= command_d;
		end
	end

endmodule

// ===== hdl/sfr_out_skid.sv =====
`timescale 1ns / 1ps

module sfr_out_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  sfr_pkg::result_t in_data,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output sfr_pkg::result_t out_data
);

	logic             out_valid_q;
	logic             skid_valid_q;
	sfr_pkg::result_t out_data_q;
	sfr_pkg::result_t skid_data_q;
	logic             advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hdl/serial_frame_receiver_sum_check.sv =====
`timescale 1ns / 1ps

// Frame receiver for a byte stream laid out as head byte, command, length,
// payload and an additive checksum. One byte is taken per clock cycle while
// s_tready is high; the parser state updates when a byte is accepted and its
// result, if any, is registered in the output buffer. This two-entry buffer keeps
// s_tready high until two results are waiting, so the input stalls only when
// the consumer holds m_tready low. Payload bytes come out with status 0 and
// their index; the checksum byte or an oversized length closes the frame with
// m_tlast set. Registers head_byte (address 0) and max_length (address 4)
// reset to 90 and 64 and should be written only while the link is idle.

module serial_frame_receiver_sum_check (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sfr_pkg::AddrW-1:0] paddr,
	input  logic [sfr_pkg::DataW-1:0] pwdata,
	output logic [sfr_pkg::DataW-1:0] prdata,
	output logic                      pready,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // rx_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,  // out_byte, byte_index, command, frame_length
	output logic [1:0]                m_tuser,  // status
	output logic                      m_tlast
);

	sfr_pkg::cfg_t    cfg;
	sfr_pkg::result_t res;
	sfr_pkg::result_t out_res;
	logic             res_valid;
	logic             accept;

	assign accept = s_tvalid && s_tready;

	sfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_tdata),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	sfr_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.frame_length, out_res.command, out_res.byte_index,
		out_res.out_byte};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.frame_end;

endmodule
